// ===== rtl/core/running_peak_and_delta_tracker_top_assert.svh =====
// Assertion macros used by the tracker update stage.
`ifndef RUNNING_PEAK_AND_DELTA_TRACKER_TOP_ASSERT_SVH
`define RUNNING_PEAK_AND_DELTA_TRACKER_TOP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define RPDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpdt assertion failed");

// Condition must hold in the cycle after the trigger.
`define RPDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpdt assertion failed");

`endif

// ===== rtl/core/rpdt_pkg.sv =====
// Package: widths and stage type of the running peak and delta tracker.
package rpdt_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int DELTA_WIDTH  = SAMPLE_WIDTH + 1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [DELTA_WIDTH-1:0]  t_delta;

    typedef struct packed {
        logic    valid;
        logic    mode;
        t_sample sample;
    } t_stage;

endpackage

// ===== rtl/core/rpdt_in_if.sv =====
// Interface: input channel carrying sample and clear items.
interface rpdt_in_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        mode;
    logic signed [rpdt_pkg::SAMPLE_WIDTH-1:0]    sample_value;

    modport source (output valid, output mode, output sample_value, input ready);
    modport sink   (input valid, input mode, input sample_value, output ready);
endinterface

// ===== rtl/core/rpdt_out_if.sv =====
// Interface: result channel carrying the six running extremes.
interface rpdt_out_if;
    logic                                        valid;
    logic                                        ready;
    logic        [rpdt_pkg::SAMPLE_WIDTH-1:0]    peak_abs;
    logic signed [rpdt_pkg::SAMPLE_WIDTH-1:0]    min_value;
    logic        [rpdt_pkg::SAMPLE_WIDTH-2:0]    max_value;
    logic        [rpdt_pkg::SAMPLE_WIDTH-1:0]    peak_abs_delta;
    logic        [rpdt_pkg::SAMPLE_WIDTH-1:0]    max_delta;
    logic signed [rpdt_pkg::DELTA_WIDTH-1:0]     min_delta;

    modport source (output valid, output peak_abs, output min_value, output max_value,
                    output peak_abs_delta, output max_delta, output min_delta,
                    input ready);
    modport sink   (input valid, input peak_abs, input min_value, input max_value,
                    input peak_abs_delta, input max_delta, input min_delta,
                    output ready);
endinterface

// ===== rtl/core/running_peak_and_delta_tracker_top.sv =====
// Top level of the running peak and delta tracker.
//
//  channel  | dir | payload
//  ---------+-----+----------------------------------------------------------
//  i_in     | in  | mode, sample_value
//  o_out    | out | peak_abs, min_value, max_value, peak_abs_delta,
//           |     | max_delta, min_delta
//
// One item per cycle while the result is not stalled: an input register feeds
// the compare/subtract update, whose state registers are the held result.
// A clear item zeroes all tracking and gives no result.
// Reset is synchronous; all tracking state returns to zero with no step history.
// A stalled result holds the state; the input register still takes one item.
module running_peak_and_delta_tracker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpdt_in_if.sink     i_in,
    rpdt_out_if.source  o_out
);

    rpdt_pkg::t_stage stage;
    logic             advance;

    rpdt_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_stage   (stage)
    );

    rpdt_update u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .o_advance (advance),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/core/rpdt_in_stage.sv =====
// Input register stage of the tracker.
module rpdt_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rpdt_in_if.sink             i_in,
    input  logic                i_advance,
    output rpdt_pkg::t_stage    o_stage
);

    rpdt_pkg::t_stage r_stage;

    assign i_in.ready = !r_stage.valid || i_advance;
    assign o_stage    = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_in.ready) begin
            r_stage.valid <= i_in.valid;
        end
        // payload needs no reset
        if (i_in.ready && i_in.valid) begin
            r_stage.mode   <= i_in.mode;
            r_stage.sample <= i_in.sample_value;
        end
    end

endmodule

// ===== rtl/core/rpdt_update.sv =====
// Extreme tracking state and result register of the tracker.
`include "running_peak_and_delta_tracker_top_assert.svh"

module rpdt_update (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpdt_pkg::t_stage    i_stage,
    output logic                o_advance,
    rpdt_out_if.source          o_out
);

    localparam int SW = rpdt_pkg::SAMPLE_WIDTH;
    localparam int DW = rpdt_pkg::DELTA_WIDTH;

    logic                  r_out_valid;
    logic [SW-1:0]         r_peak_abs;
    rpdt_pkg::t_sample     r_min;
    logic [SW-2:0]         r_max;
    logic [SW-1:0]         r_peak_abs_delta;
    logic [SW-1:0]         r_max_delta;
    rpdt_pkg::t_delta      r_min_delta;
    rpdt_pkg::t_sample     r_prev;
    logic                  r_have_prev;

    logic [SW-1:0]         n_peak_abs;
    rpdt_pkg::t_sample     n_min;
    logic [SW-2:0]         n_max;
    logic [SW-1:0]         n_peak_abs_delta;
    logic [SW-1:0]         n_max_delta;
    rpdt_pkg::t_delta      n_min_delta;

    rpdt_pkg::t_delta      s_ext;
    rpdt_pkg::t_delta      d;
    logic [SW-1:0]         abs_s;
    logic [SW-1:0]         abs_d;
    logic                  take_sample;
    logic                  take_clear;

    assign o_advance   = !r_out_valid || o_out.ready;
    assign take_sample = i_stage.valid && o_advance && (i_stage.mode == rpdt_pkg::MODE_SAMPLE);
    assign take_clear  = i_stage.valid && o_advance && (i_stage.mode == rpdt_pkg::MODE_CLEAR);

    always_comb begin
        rpdt_pkg::t_delta neg_s;
        rpdt_pkg::t_delta neg_d;
        s_ext = {i_stage.sample[SW-1], i_stage.sample};
        d     = s_ext - {r_prev[SW-1], r_prev};
        neg_s = -s_ext;
        neg_d = -d;
        // magnitudes fit SW bits: at most 2^(SW-1) and 2^SW - 1
        abs_s = s_ext[DW-1] ? neg_s[SW-1:0] : s_ext[SW-1:0];
        abs_d = d[DW-1]     ? neg_d[SW-1:0] : d[SW-1:0];

        n_peak_abs       = (abs_s > r_peak_abs) ? abs_s : r_peak_abs;
        n_min            = (i_stage.sample < r_min) ? i_stage.sample : r_min;
        n_max            = (i_stage.sample > $signed({1'b0, r_max}))
                           ? i_stage.sample[SW-2:0] : r_max;
        n_peak_abs_delta = r_peak_abs_delta;
        n_max_delta      = r_max_delta;
        n_min_delta      = r_min_delta;
        // no step on the first sample after reset or clear
        if (r_have_prev) begin
            if (abs_d > r_peak_abs_delta) n_peak_abs_delta = abs_d;
            if (d > $signed({1'b0, r_max_delta})) n_max_delta = d[SW-1:0];
            if (d < r_min_delta) n_min_delta = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || take_clear) begin
            r_peak_abs       <= '0;
            r_min            <= '0;
            r_max            <= '0;
            r_peak_abs_delta <= '0;
            r_max_delta      <= '0;
            r_min_delta      <= '0;
            r_prev           <= '0;
            r_have_prev      <= 1'b0;
        end else if (take_sample) begin
            r_peak_abs       <= n_peak_abs;
            r_min            <= n_min;
            r_max            <= n_max;
            r_peak_abs_delta <= n_peak_abs_delta;
            r_max_delta      <= n_max_delta;
            r_min_delta      <= n_min_delta;
            r_prev           <= i_stage.sample;
            r_have_prev      <= 1'b1;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= take_sample;
        end
    end

    // state only moves on advance, so it doubles as the held result
    assign o_out.valid          = r_out_valid;
    assign o_out.peak_abs       = r_peak_abs;
    assign o_out.min_value      = r_min;
    assign o_out.max_value      = r_max;
    assign o_out.peak_abs_delta = r_peak_abs_delta;
    assign o_out.max_delta      = r_max_delta;
    assign o_out.min_delta      = r_min_delta;

    `RPDT_ASSERT_NEXT(a_clear_zeroes, i_clk, i_rst_n, take_clear,
        !r_have_prev && r_peak_abs == '0 && r_min == '0 && r_max == '0 && !r_out_valid)
    `RPDT_ASSERT_NEXT(a_sample_gives_result, i_clk, i_rst_n, take_sample, r_out_valid)
    `RPDT_ASSERT_SAME(a_peak_covers_max, i_clk, i_rst_n, 1'b1,
        r_peak_abs >= {1'b0, r_max})
    `RPDT_ASSERT_SAME(a_peak_delta_covers_max, i_clk, i_rst_n, 1'b1,
        r_peak_abs_delta >= r_max_delta)
    `RPDT_ASSERT_SAME(a_no_step_without_prev, i_clk, i_rst_n, !r_have_prev,
        r_peak_abs_delta == '0 && r_min_delta == '0)

endmodule
